>>> rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file of the opening filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CMO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CMO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cmo_pkg.sv
// Shared types and constants of the cross-window opening filter.
`timescale 1ns / 1ps

package cmo_pkg;

    localparam int PIX_W        = 8;
    localparam int ROW_W        = 13;
    localparam int WIDTH_REG_W  = 11;
    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int MAX_HEIGHT   = 4096;
    localparam int WIDTH_RESET  = 256;
    localparam int HEIGHT_RESET = 256;

    localparam logic [PIX_W-1:0] KEY_MAX = 8'hFF;
    localparam logic [PIX_W-1:0] KEY_MIN = 8'h00;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic has_result;
        logic active;
        logic tail;
        logic done;
        logic at_final;
        logic at_origin;
    } stage_stat_t;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] pixel;
    } out_item_t;

endpackage

>>> rtl/core/cmo_line_store.sv
// Two-row line memory: one word per column, one byte lane per row parity.
`timescale 1ns / 1ps

module cmo_line_store #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               we,
    input  logic [AW-1:0]                      waddr,
    input  logic                               wlane,
    input  logic [cmo_pkg::PIX_W-1:0]          wdata,
    input  logic [AW-1:0]                      raddr0,
    input  logic [AW-1:0]                      raddr1,
    output logic [1:0][cmo_pkg::PIX_W-1:0]     rdata0,
    output logic [1:0][cmo_pkg::PIX_W-1:0]     rdata1
);

    logic [1:0][cmo_pkg::PIX_W-1:0] mem [DEPTH];
    logic [1:0][cmo_pkg::PIX_W-1:0] rd0_reg;
    logic [1:0][cmo_pkg::PIX_W-1:0] rd1_reg;
    logic                           hit0_reg;
    logic                           hit1_reg;
    logic                           wlane_reg;
    logic [cmo_pkg::PIX_W-1:0]      wdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr][wlane] <= wdata;
        end
        rd0_reg   <= mem[raddr0];
        rd1_reg   <= mem[raddr1];
        wlane_reg <= wlane;
        wdata_reg <= wdata;
    end

    // Track a write that lands on a word read in the same cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit0_reg <= 1'b0;
            hit1_reg <= 1'b0;
        end
        else
        begin
            hit0_reg <= we && (waddr == raddr0);
            hit1_reg <= we && (waddr == raddr1);
        end
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            rdata0[l] = (hit0_reg && (wlane_reg == 1'(l))) ? wdata_reg : rd0_reg[l];
            rdata1[l] = (hit1_reg && (wlane_reg == 1'(l))) ? wdata_reg : rd1_reg[l];
        end
    end

endmodule

>>> rtl/core/cmo_cross_stage.sv
// One cross-window pass: position counters, line memory and window compare.
`timescale 1ns / 1ps

module cmo_cross_stage #(
    parameter int MAX_WIDTH = 1024,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic [AW-1:0]                 last_col,
    input  logic [cmo_pkg::ROW_W-1:0]     height,
    input  logic [cmo_pkg::PIX_W-1:0]     key,
    input  logic                          step,
    input  logic                          has_below,
    input  logic [cmo_pkg::PIX_W-1:0]     below,
    output logic [cmo_pkg::PIX_W-1:0]     result,
    output cmo_pkg::stage_stat_t          stat
);

    logic [cmo_pkg::ROW_W-1:0]      row_reg;
    logic [cmo_pkg::ROW_W-1:0]      row_next;
    logic [AW-1:0]                  col_reg;
    logic [AW-1:0]                  col_next;
    logic [cmo_pkg::PIX_W-1:0]      left_reg;
    logic [1:0][cmo_pkg::PIX_W-1:0] rd0;
    logic [1:0][cmo_pkg::PIX_W-1:0] rd1;
    logic [cmo_pkg::PIX_W-1:0]      win_c;
    logic [cmo_pkg::PIX_W-1:0]      win_u;
    logic [cmo_pkg::PIX_W-1:0]      win_r;
    logic                           first_col;
    logic                           end_col;
    logic                           hit;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (step)
        begin
            if (col_reg == last_col)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Left neighbor is the center of the previous column.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            left_reg <= win_c;
        end
    end

    // Prefetch the words of the next position: its column and the one to its right.
    cmo_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (step && has_below),
        .waddr  (col_reg),
        .wlane  (row_reg[0]),
        .wdata  (below),
        .raddr0 (col_next),
        .raddr1 (col_next + 1'b1),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    always_comb
    begin
        win_c     = rd0[~row_reg[0]];
        win_u     = rd0[row_reg[0]];
        win_r     = rd1[~row_reg[0]];
        first_col = (col_reg == '0);
        end_col   = (col_reg == last_col);
        hit = (win_c == key)
            || ((row_reg >= cmo_pkg::ROW_W'(2)) && (win_u == key))
            || (!first_col && (left_reg == key))
            || (!end_col && (win_r == key))
            || (has_below && (below == key));
        result = hit ? key : win_c;

        stat.has_result = (row_reg != '0);
        stat.active     = (row_reg < height);
        stat.tail       = (row_reg == height);
        stat.done       = (row_reg > height);
        stat.at_final   = (row_reg == height) && end_col;
        stat.at_origin  = (row_reg == '0) && first_col;
    end

endmodule

>>> rtl/core/cmo_out_buf.sv
// Two-entry result buffer between the filter core and the output stream.
`timescale 1ns / 1ps

module cmo_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cmo_pkg::out_item_t  push_item,
    output logic                ready,
    output logic                m_valid,
    input  logic                m_ready,
    output cmo_pkg::out_item_t  m_item
);

    cmo_pkg::out_item_t entry_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               pop;

    always_comb
    begin
        m_valid    = (count_reg != 2'd0);
        ready      = (count_reg != 2'd2);
        m_item     = entry_reg[rd_ptr_reg];
        pop        = m_valid && m_ready;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/core/cross_morphological_opening.sv
// Top level of the 3x3 cross morphological opening filter.
`timescale 1ns / 1ps

// Gray-scale opening with a plus-shaped window, one raster pixel per clock
// while the output buffer has room. Pixels enter as requests with tuser = 0;
// the first pass (dilation, key 255) and the second pass (erosion, key 0) each
// keep two rows in a line memory of MAX_WIDTH words, one byte lane per row
// parity, read at two columns every cycle with a registered read. Reads are
// prefetched for the next position, and a write that hits a word read in the
// same cycle is forwarded. Results trail the input by two rows and leave
// through a two-entry buffer, so input keeps flowing while one result waits.
// After the W*H pixels of a frame, send 2*W flush requests (tuser = 1); the
// final result carries tlast and the frame restarts. Flushes during pixel
// input and pixels during the flush tail are dropped. A register write
// restarts the frame; write only while no result is outstanding. The
// memories need no clearing pass after reset.

`include "assert_macros.svh"

module cross_morphological_opening #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream. tdata: pixel_in[7:0]. tuser: action[0].
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cmo_pkg::PIX_W-1:0]         s_axis_tdata,
    input  logic [0:0]                        s_axis_tuser,
    // Output stream. tdata: pixel_out[7:0]. tlast: last_pixel.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [cmo_pkg::PIX_W-1:0]         m_axis_tdata,
    output logic                              m_axis_tlast,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [cmo_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [cmo_pkg::CFG_W-1:0]         cfg_wr_data
);

    localparam int AW        = $clog2(MAX_WIDTH);
    localparam int DEF_WIDTH = (MAX_WIDTH < cmo_pkg::WIDTH_RESET) ?
                               MAX_WIDTH : cmo_pkg::WIDTH_RESET;

    // Configuration: width is held as its last column index.
    logic [AW-1:0]               last_col_reg;
    logic [AW-1:0]               last_col_next;
    logic [cmo_pkg::ROW_W-1:0]   height_reg;
    logic [cmo_pkg::ROW_W-1:0]   height_next;
    logic [31:0]                 width_val;

    // Stream control.
    logic                        accept;
    logic                        is_flush;
    logic                        restart;
    logic                        step1;
    logic                        step2;
    logic                        has_below2;
    logic                        push;
    logic                        buf_ready;
    logic                        out_valid;

    cmo_pkg::stage_stat_t        s1_stat;
    cmo_pkg::stage_stat_t        s2_stat;
    logic [cmo_pkg::PIX_W-1:0]   s1_res;
    logic [cmo_pkg::PIX_W-1:0]   s2_res;
    cmo_pkg::out_item_t          push_item;
    cmo_pkg::out_item_t          out_item;

    // Clamp the written values into their legal ranges.
    always_comb
    begin
        last_col_next = last_col_reg;
        height_next   = height_reg;
        width_val     = 32'(cfg_wr_data[cmo_pkg::WIDTH_REG_W-1:0]);
        if (width_val == 32'd0)
        begin
            width_val = 32'd1;
        end
        if (width_val > 32'(MAX_WIDTH))
        begin
            width_val = 32'(MAX_WIDTH);
        end
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                cmo_pkg::REG_IMAGE_WIDTH:
                begin
                    last_col_next = AW'(width_val - 32'd1);
                end
                cmo_pkg::REG_IMAGE_HEIGHT:
                begin
                    if (cfg_wr_data == '0)
                    begin
                        height_next = cmo_pkg::ROW_W'(1);
                    end
                    else if (cfg_wr_data > cmo_pkg::ROW_W'(cmo_pkg::MAX_HEIGHT))
                    begin
                        height_next = cmo_pkg::ROW_W'(cmo_pkg::MAX_HEIGHT);
                    end
                    else
                    begin
                        height_next = cfg_wr_data;
                    end
                end
                default:
                begin
                    last_col_next = last_col_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= AW'(DEF_WIDTH - 1);
            height_reg   <= cmo_pkg::ROW_W'(cmo_pkg::HEIGHT_RESET);
        end
        else
        begin
            last_col_reg <= last_col_next;
            height_reg   <= height_next;
        end
    end

    // Route each request. While pixel rows come in, a pixel steps the first
    // pass and its pass-one result steps the second pass. The first flush
    // row completes pass one on the bottom row; once pass one is done, flushes
    // step the second pass alone on the bottom row. Anything else is dropped.
    always_comb
    begin
        s_axis_tready = buf_ready;
        accept        = s_axis_tvalid && s_axis_tready;
        is_flush      = (s_axis_tuser[0] == cmo_pkg::ACT_FLUSH);
        step1         = accept && ((s1_stat.active && !is_flush) ||
                                   (s1_stat.tail && is_flush));
        step2         = (step1 && s1_stat.has_result) ||
                        (accept && is_flush && s1_stat.done);
        has_below2    = !s1_stat.done;
        push          = step2 && s2_stat.has_result;
        push_item.pixel = s2_res;
        push_item.last  = s2_stat.at_final;
        // Restart the frame on its final result or on any register write.
        restart       = cfg_wr_en || (push && s2_stat.at_final);
    end

    cmo_cross_stage #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dilate (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .last_col  (last_col_reg),
        .height    (height_reg),
        .key       (cmo_pkg::KEY_MAX),
        .step      (step1),
        .has_below (s1_stat.active),
        .below     (s_axis_tdata),
        .result    (s1_res),
        .stat      (s1_stat)
    );

    cmo_cross_stage #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_erode (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .last_col  (last_col_reg),
        .height    (height_reg),
        .key       (cmo_pkg::KEY_MIN),
        .step      (step2),
        .has_below (has_below2),
        .below     (s1_res),
        .result    (s2_res),
        .stat      (s2_stat)
    );

    // Hold results until the output side takes them.
    cmo_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .ready     (buf_ready),
        .m_valid   (out_valid),
        .m_ready   (m_axis_tready),
        .m_item    (out_item)
    );

    always_comb
    begin
        m_axis_tvalid = out_valid;
        m_axis_tdata  = out_item.pixel;
        m_axis_tlast  = out_item.last;
    end

    // The second pass never reaches the bottom row before pass one is done.
    `CMO_ASSERT_IMP(a_pass_order, clk, rst_n, !s1_stat.done, !s2_stat.tail,
        "erosion pass reached bottom row ahead of dilation pass")

    // The second pass only produces results behind the first pass.
    `CMO_ASSERT_IMP(a_pass_lag, clk, rst_n, s2_stat.has_result,
        s1_stat.has_result || s1_stat.done, "erosion pass ahead of dilation pass")

    // The final result of a frame puts both passes back at the origin.
    `CMO_ASSERT_NEXT(a_frame_restart, clk, rst_n, push && push_item.last,
        s1_stat.at_origin && s2_stat.at_origin, "frame did not restart after last pixel")

endmodule

>>> tb/cmo_opening_checker.sv
// Passive checker: predicts the opened pixel stream and compares it with the output channel.
`timescale 1ns / 1ps

module cmo_opening_checker #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [cmo_pkg::PIX_W-1:0]     s_axis_tdata,   // pixel_in[7:0]
    input  logic [0:0]                    s_axis_tuser,   // action[0]
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [cmo_pkg::PIX_W-1:0]     m_axis_tdata,   // pixel_out[7:0]
    input  logic                          m_axis_tlast,
    input  logic                          cfg_wr_en,
    input  logic [cmo_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [cmo_pkg::CFG_W-1:0]     cfg_wr_data,
    output int                            fail_count,
    output int                            backlog
);

    // Two rows per pass, selected by row parity.
    logic [cmo_pkg::PIX_W-1:0] raw_lines [0:2*MAX_WIDTH-1];
    logic [cmo_pkg::PIX_W-1:0] dil_lines [0:2*MAX_WIDTH-1];

    int unsigned cfg_w, cfg_h;
    int unsigned in_col, in_row, mid_col, mid_row, out_cnt;

    cmo_pkg::out_item_t opened_q [$];
    cmo_pkg::out_item_t want;

    function automatic int unsigned line_addr(input int unsigned r, input int unsigned c);
        return (r % 2) * MAX_WIDTH + (c % MAX_WIDTH);
    endfunction

    function automatic logic [cmo_pkg::PIX_W-1:0] line_px(input bit from_dil,
                                                          input int unsigned r,
                                                          input int unsigned c);
        return from_dil ? dil_lines[line_addr(r, c)] : raw_lines[line_addr(r, c)];
    endfunction

    // Plus-shaped window: give key if the center or any present neighbor holds it.
    function automatic logic [cmo_pkg::PIX_W-1:0] plus_window(
        input bit                        from_dil,
        input int unsigned               r,
        input int unsigned               c,
        input bit                        has_below,
        input logic [cmo_pkg::PIX_W-1:0] below,
        input logic [cmo_pkg::PIX_W-1:0] key);
        logic [cmo_pkg::PIX_W-1:0] ctr;
        bit hit;
        ctr = line_px(from_dil, r, c);
        hit = (ctr == key);
        if (r >= 1 && line_px(from_dil, r - 1, c) == key) hit = 1'b1;
        if (c >= 1 && line_px(from_dil, r, c - 1) == key) hit = 1'b1;
        if (c + 1 < cfg_w && line_px(from_dil, r, c + 1) == key) hit = 1'b1;
        if (has_below && below == key) hit = 1'b1;
        return hit ? key : ctr;
    endfunction

    task automatic restart_frame();
        in_col  = 0;
        in_row  = 0;
        mid_col = 0;
        mid_row = 0;
        out_cnt = 0;
    endtask

    // Erosion stage: take one dilated pixel, give the eroded pixel one row up.
    task automatic erode_feed(input logic [cmo_pkg::PIX_W-1:0] dil, output bit emit,
                              output logic [cmo_pkg::PIX_W-1:0] res);
        emit = 1'b0;
        res  = '0;
        if (mid_row >= 1)
        begin
            res  = plus_window(1'b1, mid_row - 1, mid_col, 1'b1, dil, cmo_pkg::KEY_MIN);
            emit = 1'b1;
        end
        dil_lines[line_addr(mid_row, mid_col)] = dil;
        mid_col++;
        if (mid_col >= cfg_w)
        begin
            mid_col = 0;
            mid_row++;
        end
    endtask

    task automatic predict_opening(input logic act, input logic [cmo_pkg::PIX_W-1:0] pix);
        logic [cmo_pkg::PIX_W-1:0] dil;
        logic [cmo_pkg::PIX_W-1:0] res;
        bit emit;
        int unsigned base;
        int unsigned col;
        cmo_pkg::out_item_t item;
        emit = 1'b0;
        res  = '0;
        if (in_row < cfg_h)
        begin
            // flush requests while pixels are still due are dropped
            if (act == cmo_pkg::ACT_FLUSH) return;
            if (in_row >= 1)
            begin
                dil = plus_window(1'b0, in_row - 1, in_col, 1'b1, pix, cmo_pkg::KEY_MAX);
                erode_feed(dil, emit, res);
            end
            raw_lines[line_addr(in_row, in_col)] = pix;
            in_col++;
            if (in_col >= cfg_w)
            begin
                in_col = 0;
                in_row++;
            end
        end
        else
        begin
            // pixels during the flush tail are dropped
            if (act == cmo_pkg::ACT_PIXEL) return;
            if (mid_row < cfg_h)
            begin
                dil = plus_window(1'b0, mid_row, mid_col, 1'b0, cmo_pkg::KEY_MIN,
                                  cmo_pkg::KEY_MAX);
                erode_feed(dil, emit, res);
            end
            else
            begin
                base = (cfg_h - 1) * cfg_w;
                col  = (out_cnt >= base) ? out_cnt - base : 0;
                if (col >= cfg_w) col = 0;
                res  = plus_window(1'b1, cfg_h - 1, col, 1'b0, cmo_pkg::KEY_MIN,
                                   cmo_pkg::KEY_MIN);
                emit = 1'b1;
            end
        end
        if (!emit) return;
        out_cnt++;
        item.pixel = res;
        item.last  = (out_cnt >= cfg_w * cfg_h);
        opened_q.push_back(item);
        if (item.last) restart_frame();
    endtask

    task automatic apply_write(input logic [cmo_pkg::CFG_IDX_W-1:0] idx,
                               input logic [cmo_pkg::CFG_W-1:0] val);
        int unsigned v;
        if (idx == cmo_pkg::REG_IMAGE_WIDTH)
        begin
            v = val[cmo_pkg::WIDTH_REG_W-1:0];
            if (v < 1) v = 1;
            if (v > MAX_WIDTH) v = MAX_WIDTH;
            cfg_w = v;
        end
        else
        begin
            v = val;
            if (v < 1) v = 1;
            if (v > cmo_pkg::MAX_HEIGHT) v = cmo_pkg::MAX_HEIGHT;
            cfg_h = v;
        end
        restart_frame();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w = cmo_pkg::WIDTH_RESET;
            cfg_h = cmo_pkg::HEIGHT_RESET;
            restart_frame();
            opened_q.delete();
            fail_count = 0;
            backlog    = 0;
        end
        else
        begin
            if (cfg_wr_en) apply_write(cfg_addr, cfg_wr_data);
            if (s_axis_tvalid && s_axis_tready) predict_opening(s_axis_tuser[0], s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (opened_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual pixel %0d last %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    want = opened_q.pop_front();
                    if (m_axis_tdata !== want.pixel)
                    begin
                        $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                                 $time, want.pixel, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $display("%0t: last_pixel mismatch, expected %0b, actual %0b",
                                 $time, want.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            backlog = opened_q.size();
        end
    end

endmodule

>>> tb/cross_morphological_opening_tb.sv
// Testbench top: drives pixel, flush and register traffic into the opening filter.
`timescale 1ns / 1ps

module cross_morphological_opening_tb;

    localparam int MAX_WIDTH     = 1024;
    localparam int RANDOM_ITEMS  = 1350;
    // Cycles to let the pipeline go quiet after the last result; a flush that
    // gives no result may still be in flight when the backlog reads zero.
    localparam int SETTLE_CYCLES = 20;
    // Cycles without any request, result or write before the run is abandoned.
    localparam int STALL_LIMIT   = 2000;
    // 3x3 directed frame, pixel 0 in the low byte: both keys plus near-key values.
    localparam logic [71:0] DIR_PAT = 72'h40_00_FE_01_FF_7F_FF_80_00;

    logic                          clk;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [cmo_pkg::PIX_W-1:0]     s_axis_tdata;   // pixel_in[7:0]
    logic [0:0]                    s_axis_tuser;   // action[0]
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [cmo_pkg::PIX_W-1:0]     m_axis_tdata;   // pixel_out[7:0]
    logic                          m_axis_tlast;
    logic                          cfg_wr_en;
    logic [cmo_pkg::CFG_IDX_W-1:0] cfg_addr;
    logic [cmo_pkg::CFG_W-1:0]     cfg_wr_data;

    int fail_count;
    int backlog;
    int items_sent;
    int idle_cycles;
    bit calm;     // set: neither side idles

    cross_morphological_opening #(.MAX_WIDTH(MAX_WIDTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    cmo_opening_checker #(.MAX_WIDTH(MAX_WIDTH)) opening_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .fail_count    (fail_count),
        .backlog       (backlog)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: stall with a probability of about 18 percent unless the calm stretch is on.
    always @(negedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(99) >= 18);
    end

    // Watchdog: any request, result or register write counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("cross_morphological_opening verification failed");
                $finish;
            end
        end
    end

    // Each key in 15 of 100 draws, as the keys decide the windows; else any byte value.
    function automatic logic [cmo_pkg::PIX_W-1:0] rand_pixel();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) return cmo_pkg::KEY_MIN;
        if (sel < 30) return cmo_pkg::KEY_MAX;
        return $urandom_range(255);
    endfunction

    // Offer one request; idle first at random, then hold it until accepted.
    // Entered and left at a falling edge; tvalid stays high on return.
    task automatic send_req(input logic act, input logic [cmo_pkg::PIX_W-1:0] pix);
        while (!calm && $urandom_range(99) < 18)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= pix;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // Drop tvalid and hold off until every predicted result has left the block.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (backlog != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [cmo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cmo_pkg::CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    // Reconfigure only once the block is idle; each write also restarts the frame.
    task automatic set_size(input logic [cmo_pkg::CFG_W-1:0] w_raw,
                            input logic [cmo_pkg::CFG_W-1:0] h_raw);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(cmo_pkg::REG_IMAGE_WIDTH, w_raw);
        write_reg(cmo_pkg::REG_IMAGE_HEIGHT, h_raw);
    endtask

    // Send stop_at pixels of a w x h frame; if that completes it, send the
    // 2*w flush tail. Noise requests (dropped by the block) are mixed in.
    task automatic run_frame(input int w, input int h, input int noise_pct, input int stop_at);
        for (int i = 0; i < stop_at; i++)
        begin
            if ($urandom_range(99) < noise_pct) send_req(cmo_pkg::ACT_FLUSH, rand_pixel());
            send_req(cmo_pkg::ACT_PIXEL, rand_pixel());
            items_sent++;
            // occasionally let the output catch up completely mid-frame
            if ($urandom_range(299) == 0) drain_results();
        end
        if (stop_at < w * h) return;
        for (int j = 0; j < 2 * w; j++)
        begin
            if ($urandom_range(99) < noise_pct) send_req(cmo_pkg::ACT_PIXEL, rand_pixel());
            send_req(cmo_pkg::ACT_FLUSH, rand_pixel());
            items_sent++;
        end
    endtask

    initial
    begin
        int w;
        int h;
        int nframes;
        int stop_at;
        bit aborted;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = cmo_pkg::ACT_PIXEL;
        m_axis_tready = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = cmo_pkg::REG_IMAGE_WIDTH;
        cfg_wr_data   = '0;
        calm          = 1'b0;
        items_sent    = 0;
        idle_cycles   = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed 3x3 frame: both keys, a flush while pixels are still due,
        // and a pixel inside the flush tail; both of those get dropped.
        set_size(13'd3, 13'd3);
        send_req(cmo_pkg::ACT_FLUSH, 8'hA5);
        for (int i = 0; i < 9; i++) send_req(cmo_pkg::ACT_PIXEL, DIR_PAT[8*i +: 8]);
        send_req(cmo_pkg::ACT_FLUSH, 8'h00);
        send_req(cmo_pkg::ACT_PIXEL, cmo_pkg::KEY_MAX);
        repeat (5) send_req(cmo_pkg::ACT_FLUSH, 8'h00);

        // Zero in both registers is taken as a 1x1 image: the first flush of a
        // one-row frame gives nothing, the second gives the tlast result.
        set_size(13'd0, 13'd0);
        send_req(cmo_pkg::ACT_PIXEL, cmo_pkg::KEY_MAX);
        send_req(cmo_pkg::ACT_PIXEL, 8'h5A);
        send_req(cmo_pkg::ACT_FLUSH, 8'hFF);
        send_req(cmo_pkg::ACT_FLUSH, 8'h00);

        // Default geometry, cut short after a couple of rows by the next write.
        items_sent = 0;
        set_size(13'd256, 13'd256);
        run_frame(256, 256, 4, 530);

        // Random small frames, one to three per setting, some aborted by a write.
        while (items_sent < RANDOM_ITEMS)
        begin
            calm = (items_sent >= 700 && items_sent < 1000);
            w = $urandom_range(12);
            h = $urandom_range(8);
            set_size(cmo_pkg::CFG_W'(w), cmo_pkg::CFG_W'(h));
            if (w == 0) w = 1;
            if (h == 0) h = 1;
            nframes = $urandom_range(1, 3);
            aborted = 1'b0;
            for (int f = 0; f < nframes && !aborted; f++)
            begin
                stop_at = w * h;
                if ($urandom_range(9) == 0)
                begin
                    stop_at = $urandom_range(w * h - 1);
                    aborted = 1'b1;
                end
                run_frame(w, h, 6, stop_at);
            end
        end
        calm = 1'b0;

        // Out-of-range writes: width bits above the register are dropped, an
        // oversized width clamps to the widest row and an oversized height to
        // the tallest frame; the clamped frames are cut short.
        set_size(13'h0805, 13'd2);
        run_frame(5, 2, 0, 10);
        set_size(13'h07FF, 13'd1);
        run_frame(MAX_WIDTH, 1, 0, 32);
        set_size(13'd1, 13'h1FFF);
        run_frame(1, cmo_pkg::MAX_HEIGHT, 0, 64);

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0 && backlog == 0)
        begin
            $display("cross_morphological_opening verification clean");
        end
        else
        begin
            $display("cross_morphological_opening verification failed");
        end
        $finish;
    end

endmodule
